/* rtl/core/ccl_pkg.sv */
// shared constants, register and class codes for the code point class lookup
// ascii class rules used by the lookup sequencer; no dependencies
package ccl_pkg;

  localparam int MAX_RANGES  = 1024;
  localparam int NUM_CLASSES = 5;
  localparam int CP_W        = 21;
  localparam int CNT_W       = 11;
  localparam int IDX_W       = 10;
  localparam int CLS_W       = 3;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int ENTRY_W     = 2 * CP_W;
  localparam int ASCII_LIMIT = 128;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CLS_W-1:0] CLS_ALPHA   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_NUMERIC = 3'd1;
  localparam logic [CLS_W-1:0] CLS_SPACE   = 3'd2;
  localparam logic [CLS_W-1:0] CLS_UPPER   = 3'd3;
  localparam logic [CLS_W-1:0] CLS_LOWER   = 3'd4;

  localparam logic [2:0] REG_ALPHA_CNT   = 3'd0;
  localparam logic [2:0] REG_NUMERIC_CNT = 3'd1;
  localparam logic [2:0] REG_SPACE_CNT   = 3'd2;
  localparam logic [2:0] REG_UPPER_CNT   = 3'd3;
  localparam logic [2:0] REG_LOWER_CNT   = 3'd4;

  // fixed c-locale rules for code points below 128
  function automatic logic ascii_member(logic [CLS_W-1:0] cls, logic [6:0] c);
    logic up;
    logic low;
    logic res;
    up  = (c >= 7'h41) && (c <= 7'h5a);
    low = (c >= 7'h61) && (c <= 7'h7a);
    case (cls)
      CLS_ALPHA:   res = up | low;
      CLS_NUMERIC: res = (c >= 7'h30) && (c <= 7'h39);
      CLS_SPACE:   res = (c == 7'h20) || ((c >= 7'd9) && (c <= 7'd13));
      CLS_UPPER:   res = up;
      CLS_LOWER:   res = low;
      default:     res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/core/ccl_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module ccl_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 5120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/codepoint_class_lookup.sv */
// top level: classifies a code point against five range tables in one ram
// depends on ccl_pkg and ccl_ram
// load requests write the ram in their accept cycle and give no result; busy stays low
// ascii and bad-class queries: result in the cycle after accept, next request at once
// table queries: up to p = ceil(log2(n+1)) probes, each a ram read in S_PROBE then a compare in S_CMP;
//   result on a hit or when the search window empties; busy until the result
// rst_n is synchronous active low: clears counts and sequencer; table content not reset
module codepoint_class_lookup #(
  parameter int MAX_RANGES = ccl_pkg::MAX_RANGES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic [ccl_pkg::CLS_W-1:0]    in_class_sel,
  input  logic [ccl_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [ccl_pkg::CP_W-1:0]     in_range_start,
  input  logic [ccl_pkg::CP_W-1:0]     in_range_end,
  input  logic [ccl_pkg::CP_W-1:0]     in_code_point,
  output logic                         out_valid,
  output logic                         out_is_member,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ccl_pkg::PADDR_W-1:0]  paddr,
  input  logic [ccl_pkg::PDATA_W-1:0]  pwdata,
  output logic [ccl_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int DEPTH = ccl_pkg::NUM_CLASSES * MAX_RANGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_RANGES + 1);
  localparam int NW    = (IW > ccl_pkg::CNT_W) ? IW : ccl_pkg::CNT_W;
  localparam int SW    = (IW > ccl_pkg::IDX_W) ? IW : ccl_pkg::IDX_W;
  localparam int CP_W  = ccl_pkg::CP_W;
  localparam int CNT_W = ccl_pkg::CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_CMP} state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      lo_r, lo_nxt;
  logic [IW-1:0]      hi_r, hi_nxt;
  logic [IW-1:0]      mid_r, mid_nxt;
  logic [AW-1:0]      base_r, base_nxt;
  logic [CP_W-1:0]    cp_r, cp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_member_r, out_member_nxt;
  logic [CNT_W-1:0]   alpha_cnt_r, numeric_cnt_r, space_cnt_r, upper_cnt_r, lower_cnt_r;

  logic               accept;
  logic               cls_ok;
  logic               slot_ok;
  logic               is_ascii;
  logic [CNT_W-1:0]   sel_cnt;
  logic [IW-1:0]      sat_cnt;
  logic [AW-1:0]      cls_base;
  logic [IW-1:0]      mid;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [ccl_pkg::ENTRY_W-1:0] ram_rdata;
  logic [CP_W-1:0]    ent_start;
  logic [CP_W-1:0]    ent_end;
  logic               cfg_wr;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign cls_ok = (in_class_sel < ccl_pkg::CLS_W'(ccl_pkg::NUM_CLASSES));
  assign slot_ok = (SW'(in_entry_index) < SW'(MAX_RANGES));
  assign is_ascii = (in_code_point < CP_W'(ccl_pkg::ASCII_LIMIT));
  assign cls_base = AW'(in_class_sel) * AW'(MAX_RANGES);

  always_comb begin
    case (in_class_sel)
      ccl_pkg::CLS_ALPHA:   sel_cnt = alpha_cnt_r;
      ccl_pkg::CLS_NUMERIC: sel_cnt = numeric_cnt_r;
      ccl_pkg::CLS_SPACE:   sel_cnt = space_cnt_r;
      ccl_pkg::CLS_UPPER:   sel_cnt = upper_cnt_r;
      ccl_pkg::CLS_LOWER:   sel_cnt = lower_cnt_r;
      default:              sel_cnt = '0;
    endcase
  end

  // counts above the table size search the whole table
  assign sat_cnt = (NW'(sel_cnt) > NW'(MAX_RANGES)) ? IW'(MAX_RANGES) : IW'(sel_cnt);

  // load writes go straight into the ram in the accept cycle
  assign ram_we    = accept && (in_action == ccl_pkg::ACT_LOAD) && cls_ok && slot_ok;
  assign ram_waddr = cls_base + AW'(in_entry_index);

  logic [IW:0] mid_sum;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[IW:1];
  assign ram_re    = (state_r == S_PROBE) && (lo_r < hi_r);
  assign ram_raddr = base_r + AW'(mid);

  ccl_ram #(
    .WIDTH (ccl_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_range_start, in_range_end}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent_start = ram_rdata[2*CP_W-1:CP_W];
  assign ent_end   = ram_rdata[CP_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    base_nxt       = base_r;
    cp_nxt         = cp_r;
    out_valid_nxt  = 1'b0;
    out_member_nxt = out_member_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_action == ccl_pkg::ACT_QUERY)) begin
          if (!cls_ok) begin
            out_valid_nxt  = 1'b1;
            out_member_nxt = 1'b0;
          end else if (is_ascii) begin
            out_valid_nxt  = 1'b1;
            out_member_nxt = ccl_pkg::ascii_member(in_class_sel, in_code_point[6:0]);
          end else begin
            lo_nxt    = '0;
            hi_nxt    = sat_cnt;
            base_nxt  = cls_base;
            cp_nxt    = in_code_point;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else begin
          out_valid_nxt  = 1'b1;
          out_member_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_CMP: begin
        // shared compare against the entry read in the probe cycle
        if (cp_r < ent_start) begin
          hi_nxt    = mid_r;
          state_nxt = S_PROBE;
        end else if (cp_r > ent_end) begin
          lo_nxt    = mid_r + IW'(1);
          state_nxt = S_PROBE;
        end else begin
          out_valid_nxt  = 1'b1;
          out_member_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    base_r       <= base_nxt;
    cp_r         <= cp_nxt;
    out_member_r <= out_member_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_is_member = out_member_r;

  // configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_cnt_r   <= '0;
      numeric_cnt_r <= '0;
      space_cnt_r   <= '0;
      upper_cnt_r   <= '0;
      lower_cnt_r   <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ccl_pkg::REG_ALPHA_CNT:   alpha_cnt_r   <= pwdata[CNT_W-1:0];
        ccl_pkg::REG_NUMERIC_CNT: numeric_cnt_r <= pwdata[CNT_W-1:0];
        ccl_pkg::REG_SPACE_CNT:   space_cnt_r   <= pwdata[CNT_W-1:0];
        ccl_pkg::REG_UPPER_CNT:   upper_cnt_r   <= pwdata[CNT_W-1:0];
        ccl_pkg::REG_LOWER_CNT:   lower_cnt_r   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ccl_pkg::REG_ALPHA_CNT:   prdata = ccl_pkg::PDATA_W'(alpha_cnt_r);
      ccl_pkg::REG_NUMERIC_CNT: prdata = ccl_pkg::PDATA_W'(numeric_cnt_r);
      ccl_pkg::REG_SPACE_CNT:   prdata = ccl_pkg::PDATA_W'(space_cnt_r);
      ccl_pkg::REG_UPPER_CNT:   prdata = ccl_pkg::PDATA_W'(upper_cnt_r);
      ccl_pkg::REG_LOWER_CNT:   prdata = ccl_pkg::PDATA_W'(lower_cnt_r);
      default:                  prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_PROBE))
    else $error("compare without a preceding probe");

  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (lo_r <= hi_r))
    else $error("search window inverted");

  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == ccl_pkg::ACT_QUERY) && cls_ok && !is_ascii)
      |=> ((state_r == S_PROBE) && !out_valid_r))
    else $error("table query did not start a search");

  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> ((mid >= lo_r) && (mid < hi_r)))
    else $error("probe outside search window");

  a_no_result_midsearch: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CMP) && $past(state_r == S_PROBE)) |-> !out_valid_r)
    else $error("result shown while searching");
`endif

endmodule
